>>> sv/sme_pkg.sv
// Package for the softmax base-2 exponential pipeline: types, coefficients and widths.
// Has no dependencies. All other files of the block use it by scoped names.
`default_nettype none

package sme_pkg;

  // Field widths.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned EXP_W  = 17;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned SH_W   = 4;

  // Q8.8 exponent range after clamping, held in 12 signed bits.
  localparam int unsigned XC_W = 12;
  localparam logic signed [WORD_W-1:0] X_MIN = -32'sd2048;
  localparam logic signed [WORD_W-1:0] X_MAX = 32'sd0;

  // log2(e) in Q16.16, folded into the logit scale.
  localparam logic signed [17:0] LN2_INV_Q16 = 18'sd94548;

  // Reset values of the scale register and of the folded factor derived from it.
  localparam logic signed [WORD_W-1:0] SCALE_RESET = 32'sd65536;
  localparam logic signed [WORD_W-1:0] K_RESET     = 32'sd94548;

  // Cubic coefficients for 2^f, f in [0,1), Q16.16.
  localparam logic [16:0] EXP_ONE  = 17'd65536;
  localparam logic [16:0] EXP_C1   = 17'd45426;
  localparam logic [13:0] EXP_C2   = 14'd15743;
  localparam logic [11:0] EXP_C3   = 12'd3638;
  localparam logic [7:0]  FRAC_MASK = 8'hFF;

  // Cycles from an accepted command to its result strobe.
  localparam int unsigned PIPE_DEPTH = 6;

  typedef enum logic {
    OP_DIRECT  = 1'b0,
    OP_SOFTMAX = 1'b1
  } sme_op_e;

  // Control that travels alongside each item in the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } sme_ctl_t;

endpackage

`default_nettype wire

>>> sv/sme_front.sv
// Front pipeline half: softmax score difference, log2(e)-folded scaling to Q8.8.
// Depends on sme_pkg.
`default_nettype none

module sme_front (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  var sme_pkg::sme_ctl_t               ctl_i,
  input  var sme_pkg::sme_op_e                op_i,
  input  wire logic signed [sme_pkg::WORD_W-1:0] value_i,
  input  wire logic signed [sme_pkg::WORD_W-1:0] row_max_i,
  input  wire logic signed [sme_pkg::WORD_W-1:0] k_i,
  output sme_pkg::sme_ctl_t                   ctl_o,
  output logic signed [sme_pkg::WORD_W-1:0]   x_o
);

  // Stage 1: operand select.
  sme_pkg::sme_ctl_t                  ctl1_q;
  sme_pkg::sme_op_e                   op1_q;
  logic signed [sme_pkg::WORD_W-1:0]  opnd_d, opnd_q;

  // Stage 2: scaled exponent.
  sme_pkg::sme_ctl_t                  ctl2_q;
  logic signed [63:0]                 prod;
  logic signed [sme_pkg::WORD_W-1:0]  x_d, x_q;

  always_comb begin
    if (op_i == sme_pkg::OP_SOFTMAX) begin
      opnd_d = value_i - row_max_i;
    end else begin
      opnd_d = value_i;
    end
  end

  assign prod = 64'(opnd_q) * 64'(k_i);

  always_comb begin
    if (op1_q == sme_pkg::OP_SOFTMAX) begin
      x_d = prod[47:16];
    end else begin
      x_d = opnd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= op_i;
    opnd_q <= opnd_d;
    x_q    <= x_d;
  end

  assign ctl_o = ctl2_q;
  assign x_o   = x_q;

endmodule

`default_nettype wire

>>> sv/sme_exp2.sv
// Back half of the pipeline: clamp, cubic 2^frac polynomial and integer shift.
// Depends on sme_pkg.
`default_nettype none

module sme_exp2 (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  var sme_pkg::sme_ctl_t                  ctl_i,
  input  wire logic signed [sme_pkg::WORD_W-1:0] x_i,
  output sme_pkg::sme_ctl_t                      ctl_o,
  output logic [sme_pkg::EXP_W-1:0]              exp_o
);

  // Stage 3: clamp and split, square of the fraction.
  logic signed [sme_pkg::WORD_W-1:0] xcl;
  logic [sme_pkg::XC_W-1:0]          xc;
  logic [sme_pkg::FRAC_W-1:0]        f_d, f3_q;
  logic [sme_pkg::SH_W-1:0]          sh_d, sh3_q, sh4_q, sh5_q;
  logic [15:0]                       f2_d, f2_q;
  sme_pkg::sme_ctl_t                 ctl3_q, ctl4_q, ctl5_q, ctl6_q;

  // Stage 4: linear and square terms, cube of the fraction.
  logic [23:0] cube, c1f;
  logic [29:0] c2f;
  logic [15:0] t1_q, fcub_q;
  logic [13:0] t2_q;

  // Stage 5: cubic term and sum.
  logic [27:0]               c3f;
  logic [sme_pkg::EXP_W-1:0] p_d, p_q;

  // Stage 6: shift by the integer part.
  logic [sme_pkg::EXP_W-1:0] exp_d, exp_q;

  always_comb begin
    if (x_i > sme_pkg::X_MAX) begin
      xcl = sme_pkg::X_MAX;
    end else if (x_i < sme_pkg::X_MIN) begin
      xcl = sme_pkg::X_MIN;
    end else begin
      xcl = x_i;
    end
  end

  assign xc   = xcl[sme_pkg::XC_W-1:0];
  assign f_d  = xc[sme_pkg::FRAC_W-1:0] & sme_pkg::FRAC_MASK;
  // Negated integer part, 0 to 8.
  assign sh_d = ~xc[sme_pkg::XC_W-1:sme_pkg::FRAC_W] + 4'd1;
  assign f2_d = 16'(f_d) * 16'(f_d);

  assign cube = 24'(f2_q) * 24'(f3_q);
  assign c1f  = 24'(sme_pkg::EXP_C1) * 24'(f3_q);
  assign c2f  = 30'(sme_pkg::EXP_C2) * 30'(f2_q);

  assign c3f  = 28'(sme_pkg::EXP_C3) * 28'(fcub_q);
  assign p_d  = sme_pkg::EXP_ONE + 17'(t1_q) + 17'(t2_q) + 17'(c3f[27:16]);

  assign exp_d = p_q >> sh5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
    end else begin
      ctl3_q <= ctl_i;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f3_q   <= f_d;
    f2_q   <= f2_d;
    sh3_q  <= sh_d;
    t1_q   <= c1f[23:8];
    t2_q   <= c2f[29:16];
    fcub_q <= cube[23:8];
    sh4_q  <= sh3_q;
    p_q    <= p_d;
    sh5_q  <= sh4_q;
    exp_q  <= exp_d;
  end

  assign ctl_o = ctl6_q;
  assign exp_o = exp_q;

endmodule

`default_nettype wire

>>> sv/softmax_exp2_fixed.sv
// Top level of the softmax base-2 exponential: scale register and the two pipeline halves.
// Depends on sme_pkg, sme_front and sme_exp2.
//
//   Channel   Direction  Handshake               Payload
//   ------------------------------------------------------------------------------
//   command   in         start_i, busy_o         opcode_i, value_i, row_max_i,
//                                                last_in_row_i
//   result    out        done_o (strobe)         exp_value_o, end_of_row_o
//   config    in         cfg_valid_i, cfg_ready_o cfg_data_i (logit scale, Q16.16)
//
// A command is taken at each edge where start_i is high and busy_o is low, one per
// cycle. Its result appears on the result ports, marked by done_o for one cycle, after
// two stages form the scaled Q8.8 exponent (softmax: subtract, then the 32x32 scale
// multiply; direct: value as given) and four stages evaluate the cubic and the shift.
// The result side cannot stall, so the pipeline always advances.
// busy_o is registered from each configuration transfer and is high while the folded
// factor k = (logit_scale * log2(e)) >> 16 is recomputed from the new scale.
// Reset (rst_ni low, asynchronous) empties the pipeline and restores the scale to 1.0.
`default_nettype none

module softmax_exp2_fixed (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    start_i,
  output logic                                   busy_o,
  input  wire logic                              opcode_i,
  input  wire logic signed [sme_pkg::WORD_W-1:0] value_i,
  input  wire logic signed [sme_pkg::WORD_W-1:0] row_max_i,
  input  wire logic                              last_in_row_i,
  output logic                                   done_o,
  output logic [sme_pkg::EXP_W-1:0]              exp_value_o,
  output logic                                   end_of_row_o,
  input  wire                                    cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic signed [sme_pkg::WORD_W-1:0] cfg_data_i
);

  logic                              cfg_wr;
  logic signed [sme_pkg::WORD_W-1:0] scale_d, scale_q;
  logic signed [49:0]                kprod;
  logic signed [sme_pkg::WORD_W-1:0] k_d, k_q;
  logic                              busy_d, busy_q;

  sme_pkg::sme_ctl_t                 in_ctl, mid_ctl, out_ctl;
  sme_pkg::sme_op_e                  op;
  logic signed [sme_pkg::WORD_W-1:0] x_mid;

  // The scale register accepts a transfer in every cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign scale_d     = cfg_wr ? cfg_data_i : scale_q;

  // Fold log2(e) into the scale; the factor follows the scale register in the next cycle.
  assign kprod  = 50'(scale_q) * 50'(sme_pkg::LN2_INV_Q16);
  assign k_d    = kprod[47:16];
  assign busy_d = cfg_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= sme_pkg::SCALE_RESET;
      k_q     <= sme_pkg::K_RESET;
      busy_q  <= 1'b0;
    end else begin
      scale_q <= scale_d;
      k_q     <= k_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

  assign in_ctl.valid = start_i & ~busy_q;
  assign in_ctl.last  = last_in_row_i;
  assign op           = sme_pkg::sme_op_e'(opcode_i);

  sme_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (in_ctl),
    .op_i      (op),
    .value_i   (value_i),
    .row_max_i (row_max_i),
    .k_i       (k_q),
    .ctl_o     (mid_ctl),
    .x_o       (x_mid)
  );

  sme_exp2 u_exp2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mid_ctl),
    .x_i    (x_mid),
    .ctl_o  (out_ctl),
    .exp_o  (exp_value_o)
  );

  assign done_o       = out_ctl.valid;
  assign end_of_row_o = out_ctl.last;

endmodule

`default_nettype wire

>>> sv/sme_checker.sv
// Port-level checker for softmax_exp2_fixed, attached to the top level by a bind.
// Depends on sme_pkg and on the top level's ports.
`default_nettype none

module sme_checker (
  input wire                                    clk_i,
  input wire                                    rst_ni,
  input wire                                    start_i,
  input wire                                    busy_o,
  input wire                                    opcode_i,
  input wire logic signed [sme_pkg::WORD_W-1:0] value_i,
  input wire                                    last_in_row_i,
  input wire                                    done_o,
  input wire logic [sme_pkg::EXP_W-1:0]         exp_value_o,
  input wire                                    end_of_row_o
);

  logic       acc;
  logic       rst_run;
  logic [2:0] warm_d, warm_q;

  assign acc = start_i & ~busy_o;

  // Counts edges since reset was released, stopping at the pipeline latency.
  assign warm_d = (warm_q == 3'(sme_pkg::PIPE_DEPTH)) ? warm_q : warm_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else begin
      warm_q <= warm_d;
    end
  end

  // Reset has stayed released over the whole pipeline latency.
  assign rst_run = (warm_q == 3'(sme_pkg::PIPE_DEPTH));

  // Every accepted command gives exactly one strobe, when it leaves the pipeline.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_run |-> (done_o == $past(acc, sme_pkg::PIPE_DEPTH)))
    else $error("result strobe does not match an accepted command");

  // The row-end mark stays with its element.
  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##6 (end_of_row_o == $past(last_in_row_i, sme_pkg::PIPE_DEPTH)))
    else $error("end_of_row does not follow last_in_row");

  // Results lie between 2^-8 and just below 2.0 in Q16.16.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (exp_value_o >= 17'd256 && exp_value_o <= 17'd129999))
    else $error("exp_value out of range");

  // A positive direct exponent saturates to 1.0.
  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !opcode_i && value_i > 32'sd0) |-> ##6 (exp_value_o == 17'd65536))
    else $error("positive exponent did not saturate to one");

endmodule

bind softmax_exp2_fixed sme_checker u_sme_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .opcode_i      (opcode_i),
  .value_i       (value_i),
  .last_in_row_i (last_in_row_i),
  .done_o        (done_o),
  .exp_value_o   (exp_value_o),
  .end_of_row_o  (end_of_row_o)
);

`default_nettype wire
